// ===== sv/byte_ring_buffer_peek_discard_defines.svh =====
// assertion macros for the byte ring buffer
// used by the top level only, no other dependencies
`ifndef BYTE_RING_BUFFER_PEEK_DISCARD_DEFINES_SVH
`define BYTE_RING_BUFFER_PEEK_DISCARD_DEFINES_SVH

`ifndef ASSERT_OFF
`define BRB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRB_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BRB_ASSERT(label, clk, rst_n, prop, msg)
`define BRB_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== sv/brb_pkg.sv =====
// shared constants for the byte ring buffer: action codes, field widths
// and parameter defaults; no dependencies
package brb_pkg;

    localparam int DEPTH_DEFAULT    = 1024;
    localparam int MAX_READ_DEFAULT = 64;
    localparam int SIZE_LIMIT       = 1024;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int FILL_W   = 10;
    localparam int CFG_W    = 32;
    localparam int ADDR_W   = 3;

    localparam logic [ACTION_W-1:0] ACT_PUT     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISCARD = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

    localparam logic [ADDR_W-1:0] REG_BUF_SIZE = 3'd0;

endpackage

// ===== sv/byte_ring_buffer_peek_discard.sv =====
// byte ring buffer with block admission, peek read and discard
// depends on brb_pkg and byte_ring_buffer_peek_discard_defines.svh
// put, discard, clear: one item per cycle unless busy reading or stalled; result next cycle
// read of n bytes: sequencer loaded on acceptance, then rd_data_reg, then output register;
// one byte per cycle from the single store read port unless the output stalls
// next item taken once the last byte leaves; empty read: one result in the next cycle
// reset: pointers and admission cleared, size 1024; store contents left as is
`include "byte_ring_buffer_peek_discard_defines.svh"

module byte_ring_buffer_peek_discard #(
    parameter int DEPTH    = brb_pkg::DEPTH_DEFAULT,
    parameter int MAX_READ = brb_pkg::MAX_READ_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input items
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // data_byte[7:0], count[18:8], zero pad
    input  logic [2:0]                s_tuser,   // action[1:0], first[2]
    // result items
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // out_byte[7:0], fill_level[17:8], zero pad
    output logic [1:0]                m_tuser,   // byte_valid[0], status[1]
    output logic                      m_tlast,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [brb_pkg::ADDR_W-1:0] paddr,
    input  logic [brb_pkg::CFG_W-1:0]  pwdata,
    output logic [brb_pkg::CFG_W-1:0]  prdata,
    output logic                      pready
);
    import brb_pkg::*;

    localparam int SIZE_MAX = (DEPTH < SIZE_LIMIT) ? DEPTH : SIZE_LIMIT;
    localparam int AW       = $clog2(SIZE_MAX);
    localparam int SW       = $clog2(SIZE_MAX + 1);
    localparam int RW       = $clog2(MAX_READ + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // configuration and pointer state
    logic [COUNT_W-1:0] buf_size_reg;
    logic [SW-1:0]      eff_size_reg;
    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      tail_reg;
    logic               adm_reg;
    logic               state_reg;

    // read sequencer
    logic [AW-1:0]      rptr_reg;
    logic [RW-1:0]      rem_reg;
    logic [AW-1:0]      rd_fill_reg;
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_last_reg;

    // output register
    logic               m_tvalid_reg;
    logic [BYTE_W-1:0]  m_byte_reg;
    logic               m_bvalid_reg;
    logic               m_last_reg;
    logic               m_status_reg;
    logic [AW-1:0]      m_fill_reg;

    logic [BYTE_W-1:0]  store [SIZE_MAX];

    logic [ACTION_W-1:0] s_action;
    logic [BYTE_W-1:0]   s_byte;
    logic [COUNT_W-1:0]  s_count;
    logic                s_first;

    logic               cfg_wr;
    logic [COUNT_W-1:0] cfg_val;
    logic [SW-1:0]      cfg_eff;

    logic               s_accept;
    logic               out_free;
    logic               rd_move;
    logic               rd_issue;

    logic [SW:0]        fill_wide;
    logic [AW-1:0]      fill;
    logic [SW-1:0]      free_space;
    logic               adm_next;
    logic               put_write;
    logic [SW-1:0]      head_inc;
    logic [AW-1:0]      head_next;
    logic [SW-1:0]      rptr_inc;
    logic [COUNT_W-1:0] fill_c;
    logic [COUNT_W-1:0] cnt_min;
    logic [RW-1:0]      rd_n;
    logic [SW:0]        tail_sum;
    logic [AW-1:0]      tail_next;

    assign s_action = s_tuser[1:0];
    assign s_first  = s_tuser[2];
    assign s_byte   = s_tdata[7:0];
    assign s_count  = s_tdata[18:8];

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_BUF_SIZE[2]);
    assign cfg_val = pwdata[COUNT_W-1:0];
    assign prdata  = (paddr[2] == REG_BUF_SIZE[2]) ? CFG_W'(buf_size_reg) : '0;

    always_comb begin
        if (cfg_val < COUNT_W'(2)) begin
            cfg_eff = SW'(2);
        end else if (cfg_val > COUNT_W'(SIZE_MAX)) begin
            cfg_eff = SW'(SIZE_MAX);
        end else begin
            cfg_eff = SW'(cfg_val);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign rd_move  = rd_valid_reg && out_free;
    assign rd_issue = (state_reg == ST_READ) && (rem_reg != '0) && (!rd_valid_reg || rd_move);

    // fill level from the two pointers
    always_comb begin
        if (head_reg >= tail_reg) begin
            fill_wide = (SW+1)'(head_reg) - (SW+1)'(tail_reg);
        end else begin
            fill_wide = (SW+1)'(head_reg) + (SW+1)'(eff_size_reg) - (SW+1)'(tail_reg);
        end
    end
    assign fill       = fill_wide[AW-1:0];
    assign fill_c     = COUNT_W'(fill);
    assign free_space = eff_size_reg - SW'(1) - SW'(fill);

    // block admission and put
    assign adm_next  = s_first ? (s_count <= COUNT_W'(free_space)) : adm_reg;
    assign put_write = s_accept && (s_action == ACT_PUT) && adm_next
                       && (SW'(fill) < eff_size_reg - SW'(1));
    assign head_inc  = SW'(head_reg) + SW'(1);
    assign head_next = (head_inc == eff_size_reg) ? '0 : head_inc[AW-1:0];
    assign rptr_inc  = SW'(rptr_reg) + SW'(1);

    // read length and discard step, both clamped to the fill level; read length also capped at MAX_READ
    assign cnt_min = (s_count < fill_c) ? s_count : fill_c;
    assign rd_n    = (cnt_min < COUNT_W'(MAX_READ)) ? RW'(cnt_min) : RW'(MAX_READ);
    assign tail_sum = (SW+1)'(tail_reg) + (SW+1)'(cnt_min);
    assign tail_next = (tail_sum >= (SW+1)'(eff_size_reg))
                       ? AW'(tail_sum - (SW+1)'(eff_size_reg)) : tail_sum[AW-1:0];

    always_ff @(posedge aclk) begin
        if (put_write) begin
            store[head_reg] <= s_byte;
        end
        if (rd_issue) begin
            rd_data_reg <= store[rptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_size_reg <= COUNT_W'(SIZE_LIMIT);
            eff_size_reg <= SW'(SIZE_MAX);
            head_reg     <= '0;
            tail_reg     <= '0;
            adm_reg      <= 1'b0;
            state_reg    <= ST_IDLE;
            rem_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                buf_size_reg <= cfg_val;
                eff_size_reg <= cfg_eff;
                head_reg     <= '0;
                tail_reg     <= '0;
                adm_reg      <= 1'b0;
            end

            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
                m_byte_reg   <= '0;
                m_bvalid_reg <= 1'b0;
                m_last_reg   <= 1'b1;
                m_status_reg <= 1'b0;
                m_fill_reg   <= fill;
                unique case (s_action)
                    ACT_PUT: begin
                        adm_reg <= adm_next;
                        if (put_write) begin
                            head_reg   <= head_next;
                            m_fill_reg <= fill + AW'(1);
                        end else begin
                            m_status_reg <= 1'b1;
                        end
                    end
                    ACT_READ: begin
                        if (rd_n != '0) begin
                            // results come from the sequencer instead
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= ST_READ;
                            rptr_reg     <= tail_reg;
                            rem_reg      <= rd_n;
                            rd_fill_reg  <= fill;
                        end
                    end
                    ACT_DISCARD: begin
                        tail_reg   <= tail_next;
                        m_fill_reg <= fill - AW'(cnt_min);
                    end
                    ACT_CLEAR: begin
                        head_reg   <= '0;
                        tail_reg   <= '0;
                        adm_reg    <= 1'b0;
                        m_fill_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            if (rd_issue) begin
                rd_valid_reg <= 1'b1;
                rd_last_reg  <= (rem_reg == RW'(1));
                rem_reg      <= rem_reg - RW'(1);
                rptr_reg     <= (rptr_inc == eff_size_reg) ? '0 : rptr_inc[AW-1:0];
            end else if (rd_move) begin
                rd_valid_reg <= 1'b0;
            end

            if (rd_move) begin
                m_tvalid_reg <= 1'b1;
                m_byte_reg   <= rd_data_reg;
                m_bvalid_reg <= 1'b1;
                m_last_reg   <= rd_last_reg;
                m_status_reg <= 1'b0;
                m_fill_reg   <= rd_fill_reg;
                if (rd_last_reg) begin
                    state_reg <= ST_IDLE;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_status_reg, m_bvalid_reg};
    assign m_tdata  = {6'b0, FILL_W'(m_fill_reg), m_byte_reg};

    // a held read byte must not be overwritten by the next store read
    `BRB_ASSERT_NEVER(a_rd_interlock, aclk, aresetn, rd_valid_reg && !rd_move && rd_issue, "store read over a held byte")
    // the fill level stays below the active size
    `BRB_ASSERT(a_fill_range, aclk, aresetn, SW'(fill) < eff_size_reg, "fill level reached active size")
    // put, discard and clear results show up with last set on the next cycle
    `BRB_ASSERT(a_single_result, aclk, aresetn, s_accept && s_action != ACT_READ |=> m_tvalid && m_tlast, "missing single result")
    // the remaining count never exceeds the read cap
    `BRB_ASSERT(a_rem_cap, aclk, aresetn, state_reg == ST_READ |-> rem_reg <= RW'(MAX_READ), "read count over cap")

endmodule
